// ===== rtl/ptsd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptsd_pkg
// Shared types and constants of the point to segment distance core.
// ----------------------------------------------------------------------------
package ptsd_pkg;

  localparam int COORD_BITS_DEF     = 31;
  localparam int DIST_FRAC_BITS_DEF = 8;
  localparam int DIST_BITS          = 40;

  typedef enum logic [1:0] {
    REG_INTERIOR = 2'd0,
    REG_BEFORE   = 2'd1,
    REG_BEYOND   = 2'd2,
    REG_DEGEN    = 2'd3
  } region_t;

  typedef struct packed {
    logic    valid;
    region_t region;
  } ctl_t;

endpackage

// ===== rtl/ptsd_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptsd_div_cell
// One restoring division step for both projection lanes, quotient bit K.
// ----------------------------------------------------------------------------
module ptsd_div_cell #(
  parameter int NUM_W  = 94,
  parameter int L2_W   = 63,
  parameter int Q_W    = 31,
  parameter int SIDE_W = 188,
  parameter int K      = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  ptsd_pkg::ctl_t      ctl_in,
  input  logic [L2_W-1:0]     l2_in,
  input  logic [NUM_W-1:0]    rem_x_in,
  input  logic [Q_W-1:0]      q_x_in,
  input  logic [NUM_W-1:0]    rem_y_in,
  input  logic [Q_W-1:0]      q_y_in,
  input  logic [SIDE_W-1:0]   side_in,
  output ptsd_pkg::ctl_t      ctl_out,
  output logic [L2_W-1:0]     l2_out,
  output logic [NUM_W-1:0]    rem_x_out,
  output logic [Q_W-1:0]      q_x_out,
  output logic [NUM_W-1:0]    rem_y_out,
  output logic [Q_W-1:0]      q_y_out,
  output logic [SIDE_W-1:0]   side_out
);
  import ptsd_pkg::*;

  logic [NUM_W-1:0] dvs;
  logic             ge_x;
  logic             ge_y;
  logic [Q_W-1:0]   qbit;

  assign dvs  = NUM_W'(l2_in) << K;
  assign ge_x = rem_x_in >= dvs;
  assign ge_y = rem_y_in >= dvs;
  assign qbit = Q_W'(1) << K;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    l2_out    <= l2_in;
    side_out  <= side_in;
    rem_x_out <= ge_x ? rem_x_in - dvs : rem_x_in;
    rem_y_out <= ge_y ? rem_y_in - dvs : rem_y_in;
    q_x_out   <= ge_x ? (q_x_in | qbit) : q_x_in;
    q_y_out   <= ge_y ? (q_y_in | qbit) : q_y_in;
  end

endmodule

// ===== rtl/ptsd_root_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptsd_root_cell
// One digit-by-digit square root step, root bit B.
// ----------------------------------------------------------------------------
module ptsd_root_cell #(
  parameter int VW = 80,
  parameter int RB = 40,
  parameter int B  = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  ptsd_pkg::ctl_t ctl_in,
  input  logic [VW-1:0]  e_in,
  input  logic [RB-1:0]  r_in,
  output ptsd_pkg::ctl_t ctl_out,
  output logic [VW-1:0]  e_out,
  output logic [RB-1:0]  r_out
);
  import ptsd_pkg::*;

  logic [VW:0] trial;
  logic [VW:0] e_ext;
  logic        ge;

  // (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B)
  assign trial = ((VW+1)'(r_in) << (B + 1)) + ((VW+1)'(1) << (2 * B));
  assign e_ext = (VW+1)'(e_in);
  assign ge    = e_ext >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    e_out <= ge ? VW'(e_ext - trial) : e_in;
    r_out <= ge ? (r_in | (RB'(1) << B)) : r_in;
  end

endmodule

// ===== rtl/point_to_segment_distance_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_to_segment_distance_core
// Distance from a query point to the nearest point of a segment, with region.
// ----------------------------------------------------------------------------
// Usage: drive the six coordinates and raise start for one cycle per item.
// busy is always low, so an item is taken at every edge where start is high;
// items may follow each other in consecutive cycles.
// Each item gives one result: distance (fixed point, DIST_FRAC_BITS fraction
// bits, floored square root) and region, shown for one cycle with done high.
// Path from accept to done: five front stages (differences, products, region,
// partial products, numerator), COORD_BITS division cells, four rounding and
// squaring stages, then COORD_BITS+1+DIST_FRAC_BITS square root cells.
// Throughput is one item per cycle; results leave in accept order.
// The receiver cannot stall: done is a strobe and the result is gone after it.
// Reset clears all valid bits in the pipe; items in flight are dropped.
// ----------------------------------------------------------------------------
module point_to_segment_distance_core #(
  parameter int COORD_BITS     = ptsd_pkg::COORD_BITS_DEF,
  parameter int DIST_FRAC_BITS = ptsd_pkg::DIST_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [COORD_BITS-1:0]          point_x,
  input  logic [COORD_BITS-1:0]          point_y,
  input  logic [COORD_BITS-1:0]          seg_a_x,
  input  logic [COORD_BITS-1:0]          seg_a_y,
  input  logic [COORD_BITS-1:0]          seg_b_x,
  input  logic [COORD_BITS-1:0]          seg_b_y,
  output logic                           done,
  output logic [ptsd_pkg::DIST_BITS-1:0] distance,
  output logic [1:0]                     region
);
  import ptsd_pkg::*;

  localparam int CB     = COORD_BITS;
  localparam int F      = DIST_FRAC_BITS;
  localparam int L2_W   = 2 * CB + 1;
  localparam int NUM_W  = 3 * CB + 1;
  localparam int SIDE_W = 6 * CB + 2;
  localparam int PTS_W  = 6 * CB;
  localparam int DW     = 2 * CB + 2;
  localparam int VW     = DW + 2 * F;
  localparam int RB     = CB + 1 + F;
  localparam logic signed [CB+1:0] ONE_Q = (CB+2)'(1);

  // stage a: differences
  logic                   a_valid;
  logic [PTS_W-1:0]       a_pts;
  logic signed [CB:0]     a_dx, a_dy, a_ex, a_ey;

  // stage b: products
  logic                   b_valid;
  logic [PTS_W-1:0]       b_pts;
  logic signed [2*CB+1:0] b_sqx, b_sqy, b_pdx, b_pdy;
  logic [CB-1:0]          b_magx, b_magy;
  logic [1:0]             b_neg;

  // stage c: squared length, dot product, region
  ctl_t                   c_ctl;
  logic [PTS_W-1:0]       c_pts;
  logic [L2_W-1:0]        c_l2;
  logic [L2_W-1:0]        c_dot;
  logic [CB-1:0]          c_magx, c_magy;
  logic [1:0]             c_neg;
  logic signed [2*CB+1:0] l2_sum, dot_sum;
  region_t                region_next;

  // stage d: partial products of dot * |d|
  ctl_t                   d_ctl;
  logic [PTS_W-1:0]       d_pts;
  logic [L2_W-1:0]        d_l2;
  logic [1:0]             d_neg;
  logic [2*CB:0]          d_lox, d_loy;
  logic [2*CB-1:0]        d_hix, d_hiy;
  logic [L2_W-1:0]        dot_u;
  logic [CB:0]            dot_lo;
  logic [CB-1:0]          dot_hi;

  // stage e: numerators
  ctl_t                   e_ctl;
  logic [SIDE_W-1:0]      e_side;
  logic [L2_W-1:0]        e_l2;
  logic [NUM_W-1:0]       e_nx, e_ny;

  // division chain
  ctl_t                   div_ctl  [0:CB];
  logic [L2_W-1:0]        div_l2   [0:CB];
  logic [NUM_W-1:0]       div_rx   [0:CB];
  logic [NUM_W-1:0]       div_ry   [0:CB];
  logic [CB-1:0]          div_qx   [0:CB];
  logic [CB-1:0]          div_qy   [0:CB];
  logic [SIDE_W-1:0]      div_side [0:CB];

  logic [PTS_W-1:0]       dv_pts;
  logic                   dv_negx, dv_negy;

  // stage f: signed quotient plus base, remainder
  ctl_t                   f_ctl;
  logic [PTS_W-1:0]       f_pts;
  logic [L2_W-1:0]        f_l2;
  logic signed [CB+1:0]   f_qax, f_qay;
  logic [L2_W-1:0]        f_remx, f_remy;
  logic signed [CB-1:0]   f_px, f_py, f_ax, f_ay, f_bx, f_by;

  // stage g: rounding, target, difference
  ctl_t                   g_ctl;
  logic signed [CB:0]     g_dx, g_dy;
  logic signed [CB+1:0]   tgt_x, tgt_y;
  logic signed [CB+1:0]   rnd_x, rnd_y;
  logic signed [CB+1:0]   diff_x, diff_y;

  // stage h: squares, stage i: radicand
  ctl_t                   h_ctl;
  logic signed [2*CB+1:0] h_sqx, h_sqy;
  ctl_t                   i_ctl;
  logic [VW-1:0]          i_v;

  // root chain
  ctl_t                   root_ctl [0:RB];
  logic [VW-1:0]          root_e   [0:RB];
  logic [RB-1:0]          root_r   [0:RB];

  function automatic logic signed [CB+1:0] sx2(logic [CB-1:0] v);
    sx2 = {{2{v[CB-1]}}, v};
  endfunction

  // floor quotient with sign of d, plus base coordinate
  function automatic logic signed [CB+1:0] fix_q(logic [CB-1:0] q, logic [L2_W-1:0] rm,
                                                 logic neg, logic [CB-1:0] a);
    logic signed [CB+1:0] qe;
    logic signed [CB+1:0] ae;
    qe = {2'b00, q};
    ae = sx2(a);
    if (!neg) begin
      fix_q = ae + qe;
    end else if (rm == '0) begin
      fix_q = ae - qe;
    end else begin
      fix_q = ae - qe - ONE_Q;
    end
  endfunction

  function automatic logic signed [CB+1:0] round_q(logic signed [CB+1:0] qa,
                                                   logic [L2_W-1:0] rem,
                                                   logic [L2_W-1:0] l2);
    logic [L2_W:0] r2;
    logic [L2_W:0] le;
    r2 = {rem, 1'b0};
    le = {1'b0, l2};
    // ties go to the even neighbor
    if (r2 > le || (r2 == le && qa[0])) begin
      round_q = qa + ONE_Q;
    end else begin
      round_q = qa;
    end
  endfunction

  assign busy = 1'b0;

  // stage a
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= start;
    end
  end

  always_ff @(posedge clk) begin
    a_pts <= {point_x, point_y, seg_a_x, seg_a_y, seg_b_x, seg_b_y};
    a_dx  <= {seg_b_x[CB-1], seg_b_x} - {seg_a_x[CB-1], seg_a_x};
    a_dy  <= {seg_b_y[CB-1], seg_b_y} - {seg_a_y[CB-1], seg_a_y};
    a_ex  <= {point_x[CB-1], point_x} - {seg_a_x[CB-1], seg_a_x};
    a_ey  <= {point_y[CB-1], point_y} - {seg_a_y[CB-1], seg_a_y};
  end

  // stage b
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    b_pts  <= a_pts;
    b_sqx  <= a_dx * a_dx;
    b_sqy  <= a_dy * a_dy;
    b_pdx  <= a_ex * a_dx;
    b_pdy  <= a_ey * a_dy;
    b_magx <= CB'(a_dx[CB] ? -a_dx : a_dx);
    b_magy <= CB'(a_dy[CB] ? -a_dy : a_dy);
    b_neg  <= {a_dx[CB], a_dy[CB]};
  end

  // stage c
  assign l2_sum  = b_sqx + b_sqy;
  assign dot_sum = b_pdx + b_pdy;

  always_comb begin
    if (l2_sum == '0) begin
      region_next = REG_DEGEN;
    end else if (dot_sum[2*CB+1]) begin
      region_next = REG_BEFORE;
    end else if (dot_sum[2*CB:0] > l2_sum[2*CB:0]) begin
      region_next = REG_BEYOND;
    end else begin
      region_next = REG_INTERIOR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_ctl <= '0;
    end else begin
      c_ctl <= '{valid: b_valid, region: region_next};
    end
  end

  always_ff @(posedge clk) begin
    c_pts  <= b_pts;
    c_l2   <= l2_sum[2*CB:0];
    c_dot  <= dot_sum[2*CB:0];
    c_magx <= b_magx;
    c_magy <= b_magy;
    c_neg  <= b_neg;
  end

  // stage d: dot split in two halves to keep multipliers narrow
  assign dot_u  = (c_ctl.region == REG_INTERIOR) ? c_dot : '0;
  assign dot_lo = dot_u[CB:0];
  assign dot_hi = dot_u[2*CB:CB+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      d_ctl <= '0;
    end else begin
      d_ctl <= c_ctl;
    end
  end

  always_ff @(posedge clk) begin
    d_pts <= c_pts;
    d_l2  <= c_l2;
    d_neg <= c_neg;
    d_lox <= dot_lo * c_magx;
    d_loy <= dot_lo * c_magy;
    d_hix <= dot_hi * c_magx;
    d_hiy <= dot_hi * c_magy;
  end

  // stage e
  always_ff @(posedge clk) begin
    if (rst) begin
      e_ctl <= '0;
    end else begin
      e_ctl <= d_ctl;
    end
  end

  always_ff @(posedge clk) begin
    e_side <= {d_pts, d_neg};
    e_l2   <= d_l2;
    e_nx   <= NUM_W'(d_lox) + (NUM_W'(d_hix) << (CB + 1));
    e_ny   <= NUM_W'(d_loy) + (NUM_W'(d_hiy) << (CB + 1));
  end

  assign div_ctl[0]  = e_ctl;
  assign div_l2[0]   = e_l2;
  assign div_rx[0]   = e_nx;
  assign div_ry[0]   = e_ny;
  assign div_qx[0]   = '0;
  assign div_qy[0]   = '0;
  assign div_side[0] = e_side;

  for (genvar i = 0; i < CB; i++) begin : g_div
    ptsd_div_cell #(
      .NUM_W  (NUM_W),
      .L2_W   (L2_W),
      .Q_W    (CB),
      .SIDE_W (SIDE_W),
      .K      (CB - 1 - i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl_in    (div_ctl[i]),
      .l2_in     (div_l2[i]),
      .rem_x_in  (div_rx[i]),
      .q_x_in    (div_qx[i]),
      .rem_y_in  (div_ry[i]),
      .q_y_in    (div_qy[i]),
      .side_in   (div_side[i]),
      .ctl_out   (div_ctl[i+1]),
      .l2_out    (div_l2[i+1]),
      .rem_x_out (div_rx[i+1]),
      .q_x_out   (div_qx[i+1]),
      .rem_y_out (div_ry[i+1]),
      .q_y_out   (div_qy[i+1]),
      .side_out  (div_side[i+1])
    );
  end

  // stage f
  assign {dv_pts, dv_negx, dv_negy} = div_side[CB];

  always_ff @(posedge clk) begin
    if (rst) begin
      f_ctl <= '0;
    end else begin
      f_ctl <= div_ctl[CB];
    end
  end

  always_ff @(posedge clk) begin
    f_pts  <= dv_pts;
    f_l2   <= div_l2[CB];
    f_qax  <= fix_q(div_qx[CB], L2_W'(div_rx[CB]), dv_negx, dv_pts[4*CB-1:3*CB]);
    f_qay  <= fix_q(div_qy[CB], L2_W'(div_ry[CB]), dv_negy, dv_pts[3*CB-1:2*CB]);
    f_remx <= (dv_negx && div_rx[CB] != '0) ? div_l2[CB] - L2_W'(div_rx[CB])
                                            : L2_W'(div_rx[CB]);
    f_remy <= (dv_negy && div_ry[CB] != '0) ? div_l2[CB] - L2_W'(div_ry[CB])
                                            : L2_W'(div_ry[CB]);
  end

  // stage g
  assign {f_px, f_py, f_ax, f_ay, f_bx, f_by} = f_pts;
  assign rnd_x = round_q(f_qax, f_remx, f_l2);
  assign rnd_y = round_q(f_qay, f_remy, f_l2);

  always_comb begin
    case (f_ctl.region)
      REG_INTERIOR: begin
        tgt_x = rnd_x;
        tgt_y = rnd_y;
      end
      REG_BEYOND: begin
        tgt_x = sx2(f_bx);
        tgt_y = sx2(f_by);
      end
      default: begin
        tgt_x = sx2(f_ax);
        tgt_y = sx2(f_ay);
      end
    endcase
  end

  assign diff_x = sx2(f_px) - tgt_x;
  assign diff_y = sx2(f_py) - tgt_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_ctl <= '0;
    end else begin
      g_ctl <= f_ctl;
    end
  end

  always_ff @(posedge clk) begin
    g_dx <= (CB+1)'(diff_x);
    g_dy <= (CB+1)'(diff_y);
  end

  // stage h and i
  always_ff @(posedge clk) begin
    if (rst) begin
      h_ctl <= '0;
      i_ctl <= '0;
    end else begin
      h_ctl <= g_ctl;
      i_ctl <= h_ctl;
    end
  end

  always_ff @(posedge clk) begin
    h_sqx <= g_dx * g_dx;
    h_sqy <= g_dy * g_dy;
    i_v   <= VW'(DW'(h_sqx) + DW'(h_sqy)) << (2 * F);
  end

  assign root_ctl[0] = i_ctl;
  assign root_e[0]   = i_v;
  assign root_r[0]   = '0;

  for (genvar j = 0; j < RB; j++) begin : g_root
    ptsd_root_cell #(
      .VW (VW),
      .RB (RB),
      .B  (RB - 1 - j)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl_in  (root_ctl[j]),
      .e_in    (root_e[j]),
      .r_in    (root_r[j]),
      .ctl_out (root_ctl[j+1]),
      .e_out   (root_e[j+1]),
      .r_out   (root_r[j+1])
    );
  end

  assign done     = root_ctl[RB].valid;
  assign distance = DIST_BITS'(root_r[RB]);
  assign region   = root_ctl[RB].region;

  // degenerate region only when both differences were zero
  a_degen: assert property (@(posedge clk) disable iff (rst)
    (c_ctl.valid && c_ctl.region == REG_DEGEN) |-> ($past(a_dx, 2) == '0 && $past(a_dy, 2) == '0))
    else $error("degenerate region with nonzero segment");

  // division remainders stay below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (div_ctl[CB].valid && div_ctl[CB].region == REG_INTERIOR) |->
      (div_rx[CB] < NUM_W'(div_l2[CB]) && div_ry[CB] < NUM_W'(div_l2[CB])))
    else $error("division remainder not below squared length");

  // rounded projection lies between the segment ends
  a_tgt_in: assert property (@(posedge clk) disable iff (rst)
    (f_ctl.valid && f_ctl.region == REG_INTERIOR) |->
      (((tgt_x >= sx2(f_ax) && tgt_x <= sx2(f_bx)) || (tgt_x >= sx2(f_bx) && tgt_x <= sx2(f_ax)))
       && ((tgt_y >= sx2(f_ay) && tgt_y <= sx2(f_by))
           || (tgt_y >= sx2(f_by) && tgt_y <= sx2(f_ay)))))
    else $error("projection outside segment");

  // final root remainder is at most twice the root
  a_root_rem: assert property (@(posedge clk) disable iff (rst)
    root_ctl[RB].valid |-> ((VW+1)'(root_e[RB]) <= ((VW+1)'(root_r[RB]) << 1)))
    else $error("square root not floored");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for point_to_segment_distance_core: directed geometry
// corner cases, then random queries; every result is checked against an
// in-bench distance predictor in accept order.
// ----------------------------------------------------------------------------
module tb;
  import ptsd_pkg::*;

  localparam int CW        = 31;
  localparam int FRAC      = 8;
  localparam int N_RANDOM  = 1330;
  localparam int MAX_CYCLE = 300000;
  localparam int TAIL      = 120;

  typedef struct {
    logic [CW-1:0] px, py, ax, ay, bx, by;
    int            gap;
    bit            drain;
  } query_t;

  typedef struct {
    logic [DIST_BITS-1:0] dist_val;
    region_t              rgn;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [CW-1:0] point_x = '0, point_y = '0, seg_a_x = '0, seg_a_y = '0;
  logic [CW-1:0] seg_b_x = '0, seg_b_y = '0;
  logic done;
  logic [DIST_BITS-1:0] distance;
  logic [1:0] region;

  query_t  pending_q[$];
  answer_t answer_q[$];
  int      wait_left = 0;
  int      n_sent = 0, n_checked = 0, n_bad = 0, cycle = 0;
  int      region_seen[4] = '{0, 0, 0, 0};

  point_to_segment_distance_core u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .point_x(point_x), .point_y(point_y),
    .seg_a_x(seg_a_x), .seg_a_y(seg_a_y),
    .seg_b_x(seg_b_x), .seg_b_y(seg_b_y),
    .done(done), .distance(distance), .region(region)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic signed [127:0] widen(input logic [CW-1:0] v);
    return {{(128-CW){v[CW-1]}}, v};
  endfunction

  // nearest integer to a + dot*d/l2, ties to even
  function automatic logic signed [127:0] round_proj(input logic signed [127:0] a,
      input logic signed [127:0] d, input logic signed [127:0] dot,
      input logic signed [127:0] l2);
    logic signed [127:0] num, q, r;
    num = dot * d;
    q = num / l2;
    r = num % l2;
    if (r < 0) begin
      q = q - 1;
      r = r + l2;
    end
    q = q + a;
    if (2 * r > l2 || (2 * r == l2 && q[0])) q = q + 1;
    return q;
  endfunction

  function automatic logic [63:0] fixed_root(input logic [127:0] d2);
    logic [127:0] v, c;
    logic [63:0] r;
    v = d2 << (2 * FRAC);
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = {64'd0, r | (64'd1 << b)};
      if (c * c <= v) r = c[63:0];
    end
    return r;
  endfunction

  function automatic answer_t seg_distance(input query_t t);
    logic signed [127:0] px, py, ax, ay, bx, by, dx, dy, l2, dot, tx, ty, ex, ey;
    answer_t a;
    px = widen(t.px); py = widen(t.py);
    ax = widen(t.ax); ay = widen(t.ay);
    bx = widen(t.bx); by = widen(t.by);
    dx = bx - ax; dy = by - ay;
    l2 = dx * dx + dy * dy;
    tx = ax; ty = ay;
    if (l2 == 0) begin
      a.rgn = REG_DEGEN;
    end else begin
      dot = (px - ax) * dx + (py - ay) * dy;
      if (dot < 0) begin
        a.rgn = REG_BEFORE;
      end else if (dot > l2) begin
        a.rgn = REG_BEYOND;
        tx = bx; ty = by;
      end else begin
        a.rgn = REG_INTERIOR;
        tx = round_proj(ax, dx, dot, l2);
        ty = round_proj(ay, dy, dot, l2);
      end
    end
    ex = px - tx; ey = py - ty;
    a.dist_val = DIST_BITS'(fixed_root(ex * ex + ey * ey));
    return a;
  endfunction

  function automatic logic [CW-1:0] coord(input longint v);
    return v[CW-1:0];
  endfunction

  task automatic add_query(input longint px, py, ax, ay, bx, by, input int gap,
                           input bit drain);
    query_t t;
    t.px = coord(px); t.py = coord(py);
    t.ax = coord(ax); t.ay = coord(ay);
    t.bx = coord(bx); t.by = coord(by);
    t.gap = gap; t.drain = drain;
    pending_q.insert(pending_q.size(), t);
  endtask

  function automatic logic [CW-1:0] rand_coord(input int spread);
    longint v;
    if (spread == 0) return CW'($urandom);
    v = longint'($urandom_range(0, 2 * spread)) - spread;
    return v[CW-1:0];
  endfunction

  // driver: one item per accept, followed by that item's idle gap
  always @(posedge clk) begin
    query_t t;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) n_sent <= n_sent + 1;
      if (start && busy) begin
        start <= 1'b1;
      end else if (wait_left > 0) begin
        wait_left <= wait_left - 1;
        start <= 1'b0;
      end else if (pending_q.size() > 0 &&
                   !(pending_q[0].drain && (answer_q.size() > 0 || start))) begin
        t = pending_q.pop_front();
        point_x <= t.px; point_y <= t.py;
        seg_a_x <= t.ax; seg_a_y <= t.ay;
        seg_b_x <= t.bx; seg_b_y <= t.by;
        wait_left <= t.gap;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: predict on accept, check on done
  always @(posedge clk) begin
    query_t  t;
    answer_t exp_a;
    if (!rst) begin
      if (start && !busy) begin
        t.px = point_x; t.py = point_y;
        t.ax = seg_a_x; t.ay = seg_a_y;
        t.bx = seg_b_x; t.by = seg_b_y;
        answer_q.insert(answer_q.size(), seg_distance(t));
      end
      if (done) begin
        if (answer_q.size() == 0) begin
          n_bad++;
          if (n_bad <= 10) $display("unexpected result: distance=%0d region=%0d",
                                    distance, region);
        end else begin
          exp_a = answer_q.pop_front();
          n_checked++;
          region_seen[exp_a.rgn]++;
          if (distance !== exp_a.dist_val || region !== exp_a.rgn) begin
            n_bad++;
            if (n_bad <= 10)
              $display("mismatch on result %0d: distance exp %0d got %0d, %s",
                       n_checked, exp_a.dist_val, distance,
                       $sformatf("region exp %0d got %0d", exp_a.rgn, region));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle == MAX_CYCLE) begin
      $display("timeout after %0d cycles", cycle);
      $display("[point_to_segment_distance_core] ERROR");
      $finish;
    end
  end

  initial begin
    longint lo, hi, ax, ay, sp;
    int gap;
    bit burst;
    lo = -(longint'(1) << (CW - 1));
    hi = (longint'(1) << (CW - 1)) - 1;
    // directed corners
    add_query(0, 0, 0, 0, 0, 0, 0, 0);
    add_query(lo, lo, hi, hi, hi, hi, 0, 0);
    add_query(hi, hi, lo, lo, lo, lo, 1, 0);
    add_query(lo, hi, hi, lo, hi, lo, 0, 0);
    add_query(hi, lo, lo, lo, hi, hi, 0, 0);
    add_query(lo, lo, hi, hi, lo, hi, 2, 0);
    add_query(hi, hi, lo, lo, hi, lo, 0, 0);
    add_query(-5, 3, 0, 0, 10, 0, 0, 0);
    add_query(15, -4, 0, 0, 10, 0, 0, 0);
    add_query(0, 7, 0, 0, 10, 0, 3, 0);
    add_query(10, 7, 0, 0, 10, 0, 0, 0);
    add_query(1, 0, 0, 0, 2, 2, 0, 0);
    add_query(3, 0, 0, 0, 2, 2, 0, 0);
    add_query(1, 0, 0, 0, -2, 2, 0, 0);
    add_query(-1, 0, 0, 0, 2, -2, 0, 0);
    add_query(5, 9, 3, -7, 17, 4, 0, 0);
    add_query(hi, 0, lo, 0, hi, 1, 0, 0);
    add_query(0, hi, 0, lo, 1, hi, 0, 0);
    add_query(lo, lo, 0, 0, hi, hi, 0, 0);
    add_query(0, 0, lo, hi, hi, lo, 0, 1);
    // random queries, mostly local segments so interior cases are common
    burst = 0;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 150 == 0) burst = ($urandom_range(0, 2) == 0);
      gap = burst ? 0 : $urandom_range(0, 7);
      case ($urandom_range(0, 9))
        0, 1: begin
          add_query($signed(rand_coord(0)), $signed(rand_coord(0)),
                    $signed(rand_coord(0)), $signed(rand_coord(0)),
                    $signed(rand_coord(0)), $signed(rand_coord(0)), gap,
                    (i % 400 == 399));
        end
        2: begin
          ax = $signed(rand_coord(0)); ay = $signed(rand_coord(0));
          add_query($signed(rand_coord(0)), $signed(rand_coord(0)), ax, ay, ax, ay,
                    gap, 0);
        end
        default: begin
          sp = ($urandom_range(0, 3) == 0) ? 1000000 : $urandom_range(1, 40);
          ax = $signed(rand_coord(0)) / 2; ay = $signed(rand_coord(0)) / 2;
          add_query(ax + $signed(rand_coord(sp)), ay + $signed(rand_coord(sp)), ax, ay,
                    ax + $signed(rand_coord(sp)), ay + $signed(rand_coord(sp)), gap,
                    (i % 400 == 399));
        end
      endcase
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    wait (pending_q.size() == 0);
    @(posedge clk);
    while (start || answer_q.size() > 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
    $display("%0d queries sent, %0d results checked, %0d mismatches", n_sent, n_checked,
             n_bad);
    $display("regions: interior %0d, before start %0d, beyond end %0d, degenerate %0d",
             region_seen[0], region_seen[1], region_seen[2], region_seen[3]);
    if (n_bad == 0 && answer_q.size() == 0) begin
      $display("[point_to_segment_distance_core] OK");
    end else begin
      $display("[point_to_segment_distance_core] ERROR");
    end
    $finish;
  end

endmodule

// ===== point_to_segment_distance_core.f =====
rtl/ptsd_pkg.sv
rtl/ptsd_div_cell.sv
rtl/ptsd_root_cell.sv
rtl/point_to_segment_distance_core.sv
sim/tb.sv
